[sv/tcw_pkg.sv]
// Package for the text console writer: geometry constants, codes and shared types.
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;
  localparam int unsigned CELL_W  = $clog2(CELLS);
  localparam int unsigned COL_W   = $clog2(COLUMNS);
  localparam int unsigned ROW_W   = $clog2(ROWS);

  // Character codes and cell constants.
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam int unsigned TAB_STEP   = 8;
  localparam logic [15:0] RESET_CELL = 16'h0F20;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd1;
  localparam logic [3:0] BG_RESET = 4'd0;
  localparam logic [3:0] FG_RESET = 4'd15;

  typedef enum logic [1:0] {
    REQ_PUT      = 2'd0,
    REQ_READ     = 2'd1,
    REQ_RECOLOUR = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    SW_INIT     = 2'd0,
    SW_SCROLL   = 2'd1,
    SW_RECOLOUR = 2'd2,
    SW_CLEAR    = 2'd3
  } sweep_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        did_scroll;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic   capture;
    logic   exec_put;
    logic   sweep_begin;
    sweep_e sweep_mode;
    logic   sweep_step;
    logic   respond;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    req_e req;
    logic will_scroll;
    logic sweep_last;
  } sts_t;

endpackage

`default_nettype wire

[sv/text_console_writer_top.sv]
// Top level of the text console writer: controller plus datapath.
`default_nettype none

// The block keeps a screen of 80 by 25 cells, each an attribute byte over a
// character byte, and a cursor. An item is a request on req_i; it is accepted
// at a rising edge where start is high and busy is low. Each item gives one
// result on result_o, valid for exactly one cycle while done_o is high; the
// receiver cannot hold it off, so the block never waits on the output side.
// A put that does not scroll and a read go through the accept edge, the
// execute state, and done_o in the next cycle, during which busy is already
// low and the next item can be accepted. A read addresses the screen memory
// straight from the request at the accept edge.
// A put that scrolls, a recolour and a clear walk every cell through the
// single read and single write port of the screen memory, one cell a cycle.
// The background and foreground colours are written on the cfg port
// (index 0 and 1); the user must do so only while the block is idle, which
// the block itself does not enforce. They take effect on the next item.
// After reset the block runs a clearing pass that fills every cell with a
// white blank on black; busy stays high through the pass and a drain state.
// Colour writes are taken during that pass as at any time.

module text_console_writer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  tcw_pkg::in_t                       req_i,
  output logic                               done_o,
  output tcw_pkg::out_t                      result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [3:0]                    cfg_wdata_i
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  // Sequencing of requests and of the cell sweeps.
  tcw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Screen memory, cursor arithmetic, colour registers and result register.
  tcw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[sv/tcw_ctrl.sv]
// Controller state machine of the text console writer.
`default_nettype none

module tcw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  tcw_pkg::sts_t      sts_i,
  output tcw_pkg::cmd_t      cmd_o,
  output logic               busy
);

  localparam logic [2:0] ST_INIT       = 3'd0;
  localparam logic [2:0] ST_INIT_DRAIN = 3'd1;
  localparam logic [2:0] ST_IDLE       = 3'd2;
  localparam logic [2:0] ST_EXEC       = 3'd3;
  localparam logic [2:0] ST_SWEEP      = 3'd4;
  localparam logic [2:0] ST_DRAIN      = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{capture: 1'b0, exec_put: 1'b0, sweep_begin: 1'b0,
                sweep_mode: tcw_pkg::SW_CLEAR, sweep_step: 1'b0, respond: 1'b0};
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_INIT_DRAIN;
      end
      ST_INIT_DRAIN: begin
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts_i.req)
          tcw_pkg::REQ_PUT: begin
            cmd_o.exec_put = 1'b1;
            if (sts_i.will_scroll) begin
              cmd_o.sweep_begin = 1'b1;
              cmd_o.sweep_mode  = tcw_pkg::SW_SCROLL;
              state_d           = ST_SWEEP;
            end else begin
              cmd_o.respond = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          tcw_pkg::REQ_READ: begin
            cmd_o.respond = 1'b1;
            state_d       = ST_IDLE;
          end
          tcw_pkg::REQ_RECOLOUR: begin
            cmd_o.sweep_begin = 1'b1;
            cmd_o.sweep_mode  = tcw_pkg::SW_RECOLOUR;
            state_d           = ST_SWEEP;
          end
          tcw_pkg::REQ_CLEAR: begin
            cmd_o.sweep_begin = 1'b1;
            cmd_o.sweep_mode  = tcw_pkg::SW_CLEAR;
            state_d           = ST_SWEEP;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd_o.respond = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/tcw_dp.sv]
// Datapath of the text console writer: screen memory, cursor, colours and result register.
`default_nettype none

module tcw_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  tcw_pkg::in_t                            req_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [3:0]                         cfg_wdata_i,
  input  tcw_pkg::cmd_t                           cmd_i,
  output tcw_pkg::sts_t                           sts_o,
  output logic                                    done_o,
  output tcw_pkg::out_t                           result_o
);

  localparam int unsigned CW = tcw_pkg::CELL_W;
  localparam int unsigned XW = tcw_pkg::COL_W;
  localparam int unsigned YW = tcw_pkg::ROW_W;

  logic [15:0] mem [tcw_pkg::CELLS];

  tcw_pkg::req_e    req_q;
  logic [7:0]       char_q;
  logic             idx_ok_q;
  logic [XW-1:0]    col_q, col_d;
  logic [YW-1:0]    row_q, row_d;
  logic             scroll_q, scroll_d;
  logic [CW-1:0]    cnt_q;
  tcw_pkg::sweep_e  mode_q;
  logic             pend_q;
  logic [CW-1:0]    pend_addr_q;
  tcw_pkg::sweep_e  pend_mode_q;
  logic             pend_src_ok_q;
  logic [15:0]      rdata_q;
  logic [3:0]       bg_q, fg_q;
  logic             done_q;
  tcw_pkg::out_t    res_q;

  logic [7:0]       attr;
  logic [15:0]      blank;
  logic [XW:0]      nc;
  logic [YW:0]      nr;
  logic             will_scroll;
  logic [CW:0]      src;
  logic             src_ok;
  logic             rd_en;
  logic [CW-1:0]    rd_addr;
  logic             we;
  logic [CW-1:0]    wr_addr;
  logic [15:0]      wr_data;
  logic [CW-1:0]    cur_pos;
  logic             printable;

  assign attr  = {bg_q, fg_q};
  assign blank = {attr, tcw_pkg::CH_SPACE};

  // Cursor advance for a put.
  always_comb begin
    unique case (char_q)
      tcw_pkg::CH_NEWLINE: begin
        nc = '0;
        nr = {1'b0, row_q} + (YW+1)'(1);
      end
      tcw_pkg::CH_TAB: begin
        nc = {1'b0, col_q} + (XW+1)'(tcw_pkg::TAB_STEP);
        nr = {1'b0, row_q};
      end
      default: begin
        nc = {1'b0, col_q} + (XW+1)'(1);
        nr = {1'b0, row_q};
      end
    endcase
    if (nc >= (XW+1)'(tcw_pkg::COLUMNS)) begin
      nc = '0;
      nr = nr + (YW+1)'(1);
    end
    will_scroll = (nr >= (YW+1)'(tcw_pkg::ROWS));
  end

  assign printable = (char_q != tcw_pkg::CH_NEWLINE) && (char_q != tcw_pkg::CH_TAB);
  assign cur_pos   = CW'(row_q) * CW'(tcw_pkg::COLUMNS) + CW'(col_q);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    scroll_d = scroll_q;
    if (cmd_i.capture) scroll_d = 1'b0;
    if (cmd_i.exec_put) begin
      col_d    = nc[XW-1:0];
      row_d    = will_scroll ? YW'(tcw_pkg::ROWS - 1) : nr[YW-1:0];
      scroll_d = will_scroll;
    end
  end

  // Memory read port: the input index at capture, otherwise the sweep source.
  assign src    = {1'b0, cnt_q} + (CW+1)'(tcw_pkg::COLUMNS);
  assign src_ok = (src < (CW+1)'(tcw_pkg::CELLS));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_q;
    if (cmd_i.capture) begin
      rd_addr = req_i.cell_index[CW-1:0];
      rd_en   = (req_i.cell_index < 11'(tcw_pkg::CELLS));
    end else if (cmd_i.sweep_step) begin
      if (mode_q == tcw_pkg::SW_SCROLL) begin
        rd_addr = src[CW-1:0];
        rd_en   = src_ok;
      end else if (mode_q == tcw_pkg::SW_RECOLOUR) begin
        rd_en   = 1'b1;
      end
    end
  end

  // Memory write port: the delayed sweep write, or a put at the cursor.
  always_comb begin
    we      = 1'b0;
    wr_addr = pend_addr_q;
    wr_data = tcw_pkg::RESET_CELL;
    if (pend_q) begin
      we = 1'b1;
      unique case (pend_mode_q)
        tcw_pkg::SW_INIT:     wr_data = tcw_pkg::RESET_CELL;
        tcw_pkg::SW_SCROLL:   wr_data = pend_src_ok_q ? rdata_q : blank;
        tcw_pkg::SW_RECOLOUR: wr_data = {attr, rdata_q[7:0]};
        tcw_pkg::SW_CLEAR:    wr_data = blank;
        default:              wr_data = blank;
      endcase
    end else if (cmd_i.exec_put && printable) begin
      we      = 1'b1;
      wr_addr = cur_pos;
      wr_data = {attr, char_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= tcw_pkg::req_e'(req_i.req_type);
      char_q   <= req_i.char_code;
      idx_ok_q <= rd_en;
    end
    pend_addr_q   <= cnt_q;
    pend_mode_q   <= mode_q;
    pend_src_ok_q <= src_ok;
    if (cmd_i.respond) begin
      res_q.cell_data     <= (req_q == tcw_pkg::REQ_READ && idx_ok_q) ? rdata_q : 16'd0;
      res_q.cursor_column <= 7'(col_d);
      res_q.cursor_row    <= 5'(row_d);
      res_q.did_scroll    <= scroll_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      scroll_q <= 1'b0;
      cnt_q    <= '0;
      mode_q   <= tcw_pkg::SW_INIT;
      pend_q   <= 1'b0;
      bg_q     <= tcw_pkg::BG_RESET;
      fg_q     <= tcw_pkg::FG_RESET;
      done_q   <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      scroll_q <= scroll_d;
      pend_q   <= cmd_i.sweep_step;
      done_q   <= cmd_i.respond;
      if (cmd_i.sweep_begin) begin
        cnt_q  <= '0;
        mode_q <= cmd_i.sweep_mode;
      end else if (cmd_i.sweep_step) begin
        cnt_q  <= (cnt_q == CW'(tcw_pkg::CELLS - 1)) ? '0 : cnt_q + CW'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tcw_pkg::CFG_BG: bg_q <= cfg_wdata_i;
          tcw_pkg::CFG_FG: fg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign sts_o.req         = req_q;
  assign sts_o.will_scroll = will_scroll;
  assign sts_o.sweep_last  = (cnt_q == CW'(tcw_pkg::CELLS - 1));

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

[sv/tcw_checker.sv]
// Port-level checker for the text console writer and its bind.
`default_nettype none

module tcw_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input tcw_pkg::out_t      result_o
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  // A result strobe lasts one cycle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result is shown only when the block is ready for the next item.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // A scroll leaves the cursor at column 0 of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.did_scroll |->
      result_o.cursor_column == 7'd0 &&
      result_o.cursor_row == 5'(tcw_pkg::ROWS - 1))
    else $error("scroll left the cursor off the bottom row start");

  // The reported cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.cursor_column < 7'(tcw_pkg::COLUMNS) &&
               result_o.cursor_row < 5'(tcw_pkg::ROWS))
    else $error("cursor reported off screen");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

[verif/text_console_writer_top_tb.sv]
// Self-checking testbench for the text console writer: random and directed requests.
module text_console_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A whole-screen sweep walks every cell, so the number of sweeps the random
  // part may cause is capped. The cycle limit covers the reset clearing pass, every
  // sweep, and every light item with the longest sender gap, several times over.
  localparam int unsigned SWEEP_BUDGET = 260;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned INDEX_MAX    = 2047;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          start       = 1'b0;
  logic                          busy;
  tcw_pkg::in_t                  req_i       = '0;
  logic                          done_o;
  tcw_pkg::out_t                 result_o;
  logic                          cfg_we_i    = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_idx_i   = tcw_pkg::CFG_BG;
  logic [3:0]                    cfg_wdata_i = '0;

  text_console_writer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mirror of the console: screen contents, cursor and the current colours.
  logic [15:0] screen_mirror [tcw_pkg::CELLS];
  int unsigned cursor_col;
  int unsigned cursor_row;
  logic [3:0]  bg_colour;
  logic [3:0]  fg_colour;

  // Results that accepted items still owe, oldest first.
  tcw_pkg::out_t owed_results [$];
  tcw_pkg::out_t owed_front;
  int unsigned   error_count  = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   sweeps_left  = SWEEP_BUDGET;
  int unsigned   no_gap_run   = 0;

  // Moves the cursor to (col, row), wrapping past the last column and scrolling
  // the mirror up one line past the last row. Returns 1 when it scrolled.
  function automatic logic move_cursor(int unsigned col, int unsigned row);
    if (col >= tcw_pkg::COLUMNS) begin
      col = 0;
      row++;
    end
    cursor_col = col;
    if (row >= tcw_pkg::ROWS) begin
      for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
        screen_mirror[i] = screen_mirror[i + tcw_pkg::COLUMNS];
      for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++)
        screen_mirror[i] = {bg_colour, fg_colour, tcw_pkg::CH_SPACE};
      cursor_row = tcw_pkg::ROWS - 1;
      return 1'b1;
    end
    cursor_row = row;
    return 1'b0;
  endfunction

  // Applies one request to the mirror and returns the result the block owes for it.
  function automatic tcw_pkg::out_t apply_request(tcw_pkg::in_t item);
    tcw_pkg::out_t res;
    logic          scrolled;
    logic [15:0]   data;
    scrolled = 1'b0;
    data     = '0;
    case (tcw_pkg::req_e'(item.req_type))
      tcw_pkg::REQ_PUT: begin
        if (item.char_code == tcw_pkg::CH_NEWLINE) begin
          scrolled = move_cursor(0, cursor_row + 1);
        end else if (item.char_code == tcw_pkg::CH_TAB) begin
          scrolled = move_cursor(cursor_col + tcw_pkg::TAB_STEP, cursor_row);
        end else begin
          // Every other byte, control bytes included, lands in the cell as is.
          screen_mirror[cursor_row * tcw_pkg::COLUMNS + cursor_col] =
            {bg_colour, fg_colour, item.char_code};
          scrolled = move_cursor(cursor_col + 1, cursor_row);
        end
      end
      tcw_pkg::REQ_READ: begin
        // An index past the screen reads as zero and leaves everything alone.
        if (item.cell_index < tcw_pkg::CELLS) data = screen_mirror[item.cell_index];
      end
      tcw_pkg::REQ_RECOLOUR: begin
        for (int i = 0; i < tcw_pkg::CELLS; i++)
          screen_mirror[i][15:8] = {bg_colour, fg_colour};
      end
      default: begin
        // Clear blanks the screen in the current colours; the cursor stays put.
        for (int i = 0; i < tcw_pkg::CELLS; i++)
          screen_mirror[i] = {bg_colour, fg_colour, tcw_pkg::CH_SPACE};
      end
    endcase
    res.cell_data     = data;
    res.cursor_column = cursor_col[6:0];
    res.cursor_row    = cursor_row[4:0];
    res.did_scroll    = scrolled;
    return res;
  endfunction

  // Sender gap for the next item, drawn at random, with occasional runs of
  // back-to-back items so that the block also sees a continuous stream.
  function automatic int unsigned next_gap();
    if (no_gap_run > 0) begin
      no_gap_run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) no_gap_run = $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  // Drives one item and waits for the edge that accepts it. Every call starts
  // and ends on a rising-edge time step; start is only touched once per step.
  // Busy is sampled at the falling edge, where it is stable, and the item is
  // taken at the following rising edge exactly when start is high and busy low.
  task automatic send_request(tcw_pkg::in_t item);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    owed_results.push_back(apply_request(item));
  endtask

  task automatic send_fields(tcw_pkg::req_e kind, logic [7:0] ch, logic [10:0] index);
    tcw_pkg::in_t item;
    item.req_type   = kind;
    item.char_code  = ch;
    item.cell_index = index;
    send_request(item);
  endtask

  // Holds the sender off until every owed result has come back, then lets the
  // clock run on so the block is surely idle before any colour write.
  task automatic wait_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // One colour register write; the idle edge after it keeps the write enable
  // from being lowered and raised in the same step by back-to-back writes.
  task automatic write_colour(logic [tcw_pkg::CFG_IDX_W-1:0] index, logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == tcw_pkg::CFG_BG) bg_colour = value;
    else fg_colour = value;
    @(posedge clk_i);
  endtask

  task automatic set_colours(logic [3:0] bg, logic [3:0] fg);
    write_colour(tcw_pkg::CFG_BG, bg);
    write_colour(tcw_pkg::CFG_FG, fg);
  endtask

  // True when a put of this byte at the current cursor would scroll the screen.
  function automatic logic put_would_scroll(logic [7:0] ch);
    if (cursor_row + 1 < tcw_pkg::ROWS) return 1'b0;
    if (ch == tcw_pkg::CH_NEWLINE) return 1'b1;
    if (ch == tcw_pkg::CH_TAB) return cursor_col + tcw_pkg::TAB_STEP >= tcw_pkg::COLUMNS;
    return cursor_col + 1 >= tcw_pkg::COLUMNS;
  endfunction

  // Mostly text: printable bytes with newlines and tabs, some raw bytes, reads
  // anywhere, near the cursor where text was just written or past the screen,
  // and rare whole-screen recolours and clears. Once the sweep budget is spent,
  // any request that would walk the whole screen becomes a read instead.
  function automatic tcw_pkg::in_t random_request();
    tcw_pkg::in_t item;
    int unsigned  pick;
    int unsigned  pos;
    int unsigned  back;
    pick            = $urandom_range(0, 99);
    item.cell_index = 11'($urandom_range(0, INDEX_MAX));
    item.char_code  = 8'($urandom_range(0, 255));
    if (pick < 70) begin
      item.req_type = tcw_pkg::REQ_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 10) item.char_code = tcw_pkg::CH_NEWLINE;
      else if (pick < 16) item.char_code = tcw_pkg::CH_TAB;
      else if (pick >= 26) item.char_code = 8'($urandom_range(32, 126));
    end else if (pick < 94) begin
      item.req_type = tcw_pkg::REQ_READ;
    end else if (pick < 97) begin
      item.req_type = tcw_pkg::REQ_RECOLOUR;
    end else begin
      item.req_type = tcw_pkg::REQ_CLEAR;
    end

    if (item.req_type != tcw_pkg::REQ_READ &&
        (item.req_type != tcw_pkg::REQ_PUT || put_would_scroll(item.char_code))) begin
      if (sweeps_left == 0) item.req_type = tcw_pkg::REQ_READ;
      else sweeps_left--;
    end

    if (item.req_type == tcw_pkg::REQ_READ) begin
      pick = $urandom_range(0, 9);
      pos  = cursor_row * tcw_pkg::COLUMNS + cursor_col;
      back = $urandom_range(1, 160);
      if (pick < 4) item.cell_index = 11'($urandom_range(0, tcw_pkg::CELLS - 1));
      else if (pick < 8)
        item.cell_index = (pos >= back) ? 11'(pos - back) : 11'($urandom_range(0, pos));
      else item.cell_index = 11'($urandom_range(tcw_pkg::CELLS, INDEX_MAX));
    end
    return item;
  endfunction

  // The screen right after the reset clearing pass, at both ends and past it.
  task automatic test_reset_contents();
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    send_fields(tcw_pkg::REQ_READ, 8'hFF, 11'(tcw_pkg::CELLS - 1));
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'(tcw_pkg::CELLS));
    send_fields(tcw_pkg::REQ_READ, 8'h55, 11'(INDEX_MAX));
  endtask

  // Printable and control bytes at the byte extremes, tabs and a newline;
  // bytes 00, FF, 0D and the last letter are read back from their cells.
  task automatic test_put_bytes();
    send_fields(tcw_pkg::REQ_PUT, 8'h48, 11'd0);
    send_fields(tcw_pkg::REQ_PUT, 8'h00, 11'(INDEX_MAX));
    send_fields(tcw_pkg::REQ_PUT, 8'hFF, 11'd0);
    send_fields(tcw_pkg::REQ_PUT, 8'h0D, 11'd0);
    send_fields(tcw_pkg::REQ_PUT, 8'h7F, 11'd0);
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'd1);
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'd2);
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'd3);
    send_fields(tcw_pkg::REQ_PUT, tcw_pkg::CH_TAB, 11'd0);
    send_fields(tcw_pkg::REQ_PUT, tcw_pkg::CH_TAB, 11'd0);
    send_fields(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
    send_fields(tcw_pkg::REQ_PUT, 8'h41, 11'd0);
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'(tcw_pkg::COLUMNS));
  endtask

  // New colours, then a recolour that keeps the characters and a clear that
  // blanks everything in the new colours.
  task automatic test_colour_sweeps();
    wait_until_drained();
    set_colours(4'hA, 4'h5);
    send_fields(tcw_pkg::REQ_RECOLOUR, 8'h00, 11'd0);
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'(tcw_pkg::CELLS - 1));
    send_fields(tcw_pkg::REQ_CLEAR, 8'h00, 11'd0);
    send_fields(tcw_pkg::REQ_READ, 8'h00, 11'd1);
  endtask

  // One colour setting followed by a stream of random text; now and then the
  // sender pauses until every owed result has come back.
  task automatic test_random_text(logic [3:0] bg, logic [3:0] fg, int unsigned count);
    wait_until_drained();
    set_colours(bg, fg);
    repeat (count) begin
      send_request(random_request());
      if ($urandom_range(0, 63) == 0) wait_until_drained();
    end
  endtask

  // Results are sampled at the falling edge, away from the rising edge that
  // changes them, and compared field by field with the oldest one owed.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, result_o);
        error_count++;
      end else begin
        owed_front = owed_results.pop_front();
        if (result_o.cell_data !== owed_front.cell_data) begin
          $display("%0t: cell_data expected %h actual %h",
                   $time, owed_front.cell_data, result_o.cell_data);
          error_count++;
        end
        if (result_o.cursor_column !== owed_front.cursor_column) begin
          $display("%0t: cursor_column expected %0d actual %0d",
                   $time, owed_front.cursor_column, result_o.cursor_column);
          error_count++;
        end
        if (result_o.cursor_row !== owed_front.cursor_row) begin
          $display("%0t: cursor_row expected %0d actual %0d",
                   $time, owed_front.cursor_row, result_o.cursor_row);
          error_count++;
        end
        if (result_o.did_scroll !== owed_front.did_scroll) begin
          $display("%0t: did_scroll expected %b actual %b",
                   $time, owed_front.did_scroll, result_o.did_scroll);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < tcw_pkg::CELLS; i++) screen_mirror[i] = tcw_pkg::RESET_CELL;
    cursor_col = 0;
    cursor_row = 0;
    bg_colour  = tcw_pkg::BG_RESET;
    fg_colour  = tcw_pkg::FG_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The clearing pass after reset keeps busy high; the first item simply
    // waits for it in the handshake.
    test_reset_contents();
    test_put_bytes();
    test_colour_sweeps();

    // Colour settings include every corner of the two nibbles.
    test_random_text(4'h0, 4'h0, 220);
    test_random_text(4'hF, 4'hF, 220);
    test_random_text(4'hF, 4'h0, 220);
    test_random_text(tcw_pkg::BG_RESET, tcw_pkg::FG_RESET, 220);
    test_random_text(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 220);
    test_random_text(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 220);

    // Leave a margin after the last result so a stray extra one is caught.
    wait_until_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_writer_top.sv
sv/tcw_checker.sv
verif/text_console_writer_top_tb.sv
